@@ rtl/particle_pool_engine_core_macros.svh @@
// Assertion macros for the particle pool engine.
// Each expects clk and arst_n in scope.
`ifndef PARTICLE_POOL_ENGINE_CORE_MACROS_SVH
`define PARTICLE_POOL_ENGINE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PPE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PPE_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define PPE_ASSERT(lbl, prop, msg)
`define PPE_NEVER(lbl, cond, msg)
`endif
`endif

@@ rtl/ppe_pkg.sv @@
`default_nettype none
package ppe_pkg;
	localparam int SLOT_W      = 6;
	localparam int CNT_W       = 7;
	localparam int DT_W        = 16;
	localparam int VAL_W       = 32;
	localparam int DIST_W      = 64;
	localparam int KIND_W      = 2;
	localparam int EMIT_W      = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int IN_TDATA_W  = 328;
	localparam int OUT_TDATA_W = 168;
	localparam logic [DT_W-1:0] DT_RESET = 16'd1092;
	localparam logic RK_ACK  = 1'b0;
	localparam logic RK_SURV = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		K_FRAME = 2'd0,
		K_EMIT  = 2'd1,
		K_TICK  = 2'd2,
		K_NONE  = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		R_DT   = 2'd0,
		R_CAMX = 2'd1,
		R_CAMY = 2'd2,
		R_CAMZ = 2'd3
	} reg_t;

	typedef enum logic [1:0] {
		OP_VEL  = 2'd0,
		OP_POS  = 2'd1,
		OP_DIST = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE, S_EMIT, S_LIST, S_SLOT, S_EVAL, S_OPND, S_MUL, S_ACC, S_WB, S_PUSH, S_END
	} state_t;

	typedef struct packed {
		logic       load;
		logic       opnd;
		logic       mul;
		logic       acc;
		op_t        op;
		logic [1:0] axis;
	} alu_ctrl_t;

	typedef struct packed {
		logic [VAL_W-1:0] life;
		logic [VAL_W-1:0] acc_z;
		logic [VAL_W-1:0] acc_y;
		logic [VAL_W-1:0] acc_x;
		logic [VAL_W-1:0] vel_z;
		logic [VAL_W-1:0] vel_y;
		logic [VAL_W-1:0] vel_x;
		logic [VAL_W-1:0] pos_z;
		logic [VAL_W-1:0] pos_y;
		logic [VAL_W-1:0] pos_x;
	} part_t;

	function automatic logic [OUT_TDATA_W-1:0] pack_out(
		input logic [SLOT_W-1:0] slot, input logic valid,
		input logic [VAL_W-1:0] px, input logic [VAL_W-1:0] py,
		input logic [VAL_W-1:0] pz, input logic [DIST_W-1:0] sq_dist);
		pack_out = {1'b0, sq_dist, pz, py, px, valid, slot};
	endfunction
endpackage
`default_nettype wire

@@ rtl/ppe_mem.sv @@
`default_nettype none
module ppe_mem import ppe_pkg::*; #(
	parameter int MAX_PARTICLES = 64
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               st_we,
	input  wire logic [$clog2(MAX_PARTICLES)-1:0]   st_waddr,
	input  wire part_t                              st_wdata,
	input  wire logic                               st_re,
	input  wire logic [$clog2(MAX_PARTICLES)-1:0]   st_raddr,
	output part_t                                   st_rdata,
	input  wire logic                               ls_we,
	input  wire logic [$clog2(MAX_PARTICLES):0]     ls_waddr,
	input  wire logic [$clog2(MAX_PARTICLES)-1:0]   ls_wdata,
	input  wire logic                               ls_re,
	input  wire logic [$clog2(MAX_PARTICLES):0]     ls_raddr,
	output logic [$clog2(MAX_PARTICLES)-1:0]        ls_rdata,
	input  wire logic                               fs_we,
	input  wire logic [$clog2(MAX_PARTICLES)-1:0]   fs_waddr,
	input  wire logic [$clog2(MAX_PARTICLES)-1:0]   fs_wdata,
	input  wire logic                               fs_re,
	input  wire logic [$clog2(MAX_PARTICLES)-1:0]   fs_raddr,
	output logic [$clog2(MAX_PARTICLES)-1:0]        fs_slot
);
	localparam int IDX_W = $clog2(MAX_PARTICLES);

	part_t            st_mem [MAX_PARTICLES];
	logic [IDX_W-1:0] ls_mem [2**(IDX_W+1)];
	logic [IDX_W-1:0] fs_mem [MAX_PARTICLES];
	logic [MAX_PARTICLES-1:0] fs_vld_q;
	logic [IDX_W-1:0] fs_data_q, fs_idx_q;
	logic             fs_hit_q;

	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[st_waddr] <= st_wdata;
		end
		if (st_re) begin
			st_rdata <= st_mem[st_raddr];
		end
		if (ls_we) begin
			ls_mem[ls_waddr] <= ls_wdata;
		end
		if (ls_re) begin
			ls_rdata <= ls_mem[ls_raddr];
		end
		if (fs_we) begin
			fs_mem[fs_waddr] <= fs_wdata;
		end
		if (fs_re) begin
			fs_data_q <= fs_mem[fs_raddr];
			fs_idx_q  <= fs_raddr;
		end
	end

	// unwritten free-stack entries hold their own index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_vld_q <= '0;
			fs_hit_q <= 1'b0;
		end else begin
			if (fs_we) begin
				fs_vld_q[fs_waddr] <= 1'b1;
			end
			if (fs_re) begin
				fs_hit_q <= fs_vld_q[fs_raddr];
			end
		end
	end

	assign fs_slot = fs_hit_q ? fs_data_q : fs_idx_q;
endmodule
`default_nettype wire

@@ rtl/ppe_alu.sv @@
`default_nettype none
module ppe_alu import ppe_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic              clk,
	input  wire alu_ctrl_t         ctrl,
	input  wire logic [DT_W-1:0]   dt,
	input  wire logic [VAL_W-1:0]  cam_x,
	input  wire logic [VAL_W-1:0]  cam_y,
	input  wire logic [VAL_W-1:0]  cam_z,
	input  wire part_t             rd,
	output logic [VAL_W-1:0]       vel_x,
	output logic [VAL_W-1:0]       vel_y,
	output logic [VAL_W-1:0]       vel_z,
	output logic [VAL_W-1:0]       pos_x,
	output logic [VAL_W-1:0]       pos_y,
	output logic [VAL_W-1:0]       pos_z,
	output logic [VAL_W-1:0]       acc_x,
	output logic [VAL_W-1:0]       acc_y,
	output logic [VAL_W-1:0]       acc_z,
	output logic [DIST_W-1:0]      sq_dist
);
	localparam int OP_W = VAL_W + 2;
	localparam int PR_W = 2 * OP_W;
	localparam logic signed [PR_W-1:0] SMAX = PR_W'(64'sh7FFF_FFFF);
	localparam logic signed [PR_W-1:0] SMIN = -PR_W'(64'sh8000_0000);

	logic [VAL_W-1:0] vel_q [3];
	logic [VAL_W-1:0] pos_q [3];
	logic [VAL_W-1:0] acc_q [3];
	logic [DIST_W-1:0] dist_q;
	logic signed [OP_W-1:0] opa_q, opb_q, opa_d, opb_d;
	logic signed [PR_W-1:0] prod_q, scaled, base, sum, sat;
	logic [VAL_W-1:0] cam;
	logic signed [VAL_W:0] diff;
	logic [PR_W-1:0] dsum;

	always_comb begin
		case (ctrl.axis)
			2'd0:    cam = cam_x;
			2'd1:    cam = cam_y;
			default: cam = cam_z;
		endcase
		diff = $signed({pos_q[ctrl.axis][VAL_W-1], pos_q[ctrl.axis]})
			- $signed({cam[VAL_W-1], cam});
		case (ctrl.op)
			OP_VEL: begin
				opa_d = OP_W'($signed(acc_q[ctrl.axis]));
				opb_d = $signed({{(OP_W-DT_W){1'b0}}, dt});
			end
			OP_POS: begin
				opa_d = OP_W'($signed(vel_q[ctrl.axis]));
				opb_d = $signed({{(OP_W-DT_W){1'b0}}, dt});
			end
			default: begin
				opa_d = OP_W'(diff);
				opb_d = OP_W'(diff);
			end
		endcase
		scaled = prod_q >>> FRAC_BITS;
		base = (ctrl.op == OP_VEL) ? PR_W'($signed(vel_q[ctrl.axis]))
			: PR_W'($signed(pos_q[ctrl.axis]));
		sum = base + scaled;
		if (sum > SMAX) begin
			sat = SMAX;
		end else if (sum < SMIN) begin
			sat = SMIN;
		end else begin
			sat = sum;
		end
		dsum = {{(PR_W-DIST_W){1'b0}}, dist_q} + prod_q;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			pos_q[0] <= rd.pos_x; pos_q[1] <= rd.pos_y; pos_q[2] <= rd.pos_z;
			vel_q[0] <= rd.vel_x; vel_q[1] <= rd.vel_y; vel_q[2] <= rd.vel_z;
			acc_q[0] <= rd.acc_x; acc_q[1] <= rd.acc_y; acc_q[2] <= rd.acc_z;
			dist_q <= '0;
		end
		if (ctrl.opnd) begin
			opa_q <= opa_d;
			opb_q <= opb_d;
		end
		if (ctrl.mul) begin
			prod_q <= opa_q * opb_q;
		end
		if (ctrl.acc) begin
			case (ctrl.op)
				OP_VEL:  vel_q[ctrl.axis] <= sat[VAL_W-1:0];
				OP_POS:  pos_q[ctrl.axis] <= sat[VAL_W-1:0];
				default: dist_q <= (dsum[PR_W-1:DIST_W] != '0) ? '1 : dsum[DIST_W-1:0];
			endcase
		end
	end

	assign vel_x = vel_q[0];
	assign vel_y = vel_q[1];
	assign vel_z = vel_q[2];
	assign pos_x = pos_q[0];
	assign pos_y = pos_q[1];
	assign pos_z = pos_q[2];
	assign acc_x = acc_q[0];
	assign acc_y = acc_q[1];
	assign acc_z = acc_q[2];
	assign sq_dist = dist_q;
endmodule
`default_nettype wire

@@ rtl/particle_pool_engine_core.sv @@
// channel  dir  handshake            payload
// s        in   s_tvalid/s_tready    s_tuser kind, s_tdata particle / emit count
// m        out  m_tvalid/m_tready    m_tuser result kind, m_tdata, m_tlast
// cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
// begin_frame and emit both return to idle; emit also waits out an output stall.
// Tick runs on the shared 34x34 multiplier, doing 9 multiply-accumulate steps per
// surviving particle; a dead particle skips them and its slot is freed.
// Reset is asynchronous; no clearing pass, particle and list stores are undefined until written.
// A full output register stalls the sequencer; s_tready is low while busy.
`default_nettype none
`include "particle_pool_engine_core_macros.svh"
module particle_pool_engine_core import ppe_pkg::*; #(
	parameter int MAX_PARTICLES = 64,
	parameter int FRAC_BITS     = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// req_count, pos_x/y/z, vel_x/y/z, acc_x/y/z, lifetime
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// kind
	input  wire logic [KIND_W-1:0]      s_tuser,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// slot, slot_valid, out_pos_x/y/z, squared_distance, pad
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	// result_kind
	output logic                        m_tuser,
	output logic                        m_tlast,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [VAL_W-1:0]       cfg_data
);
	localparam int IDX_W = $clog2(MAX_PARTICLES);
	localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_PARTICLES);
	localparam logic signed [VAL_W:0] LIFE_MIN = -(VAL_W+1)'(64'sh8000_0000);

	state_t st_q, st_d;
	logic [DT_W-1:0] dt_q;
	logic [VAL_W-1:0] camx_q, camy_q, camz_q;
	logic sel_q, grant_q, pend_v_q;
	logic [CNT_W-1:0] free_q, alive_q, granted_q, attempts_q, surv_q, i_q, n_q;
	part_t inp_q, st_rdata, st_wdata;
	logic [IDX_W-1:0] slot_q, ls_rdata, fs_slot;
	logic [VAL_W-1:0] life_q;
	op_t op_q;
	logic [1:0] axis_q;
	logic [SLOT_W-1:0] pend_slot_q;
	logic [VAL_W-1:0] pend_x_q, pend_y_q, pend_z_q;
	logic [DIST_W-1:0] pend_d_q;
	logic m_tvalid_q, m_tlast_q, m_tuser_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	logic acc_in, grant_c, out_free, life_pos, go, m_load;
	logic st_we, st_re, ls_we, ls_re, fs_we, fs_re;
	logic [IDX_W-1:0] st_waddr, st_raddr;
	logic [IDX_W:0] ls_waddr, ls_raddr;
	logic [IDX_W-1:0] ls_wdata;
	logic [CNT_W-1:0] free_m1;
	logic [EMIT_W-1:0] emit_cnt;
	logic signed [VAL_W:0] life_dec;
	alu_ctrl_t ctrl;
	logic [VAL_W-1:0] vx, vy, vz, px, py, pz, ax, ay, az;
	logic [DIST_W-1:0] sq_dist;

	assign s_tready = (st_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign acc_in = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign grant_c = (attempts_q < granted_q) && (free_q != '0) && (alive_q < MAX_C);
	assign free_m1 = free_q - CNT_W'(1);
	assign emit_cnt = s_tdata[EMIT_W-1:0];
	assign life_pos = $signed(st_rdata.life) > 0;
	assign life_dec = $signed({st_rdata.life[VAL_W-1], st_rdata.life})
		- $signed({{(VAL_W+1-DT_W){1'b0}}, dt_q});
	assign go = !pend_v_q || out_free;
	assign m_load = (st_q == S_EMIT && out_free)
		|| ((st_q == S_PUSH || st_q == S_END) && go && pend_v_q);

	ppe_mem #(.MAX_PARTICLES(MAX_PARTICLES)) u_mem (
		.clk(clk), .arst_n(arst_n),
		.st_we(st_we), .st_waddr(st_waddr), .st_wdata(st_wdata),
		.st_re(st_re), .st_raddr(st_raddr), .st_rdata(st_rdata),
		.ls_we(ls_we), .ls_waddr(ls_waddr), .ls_wdata(ls_wdata),
		.ls_re(ls_re), .ls_raddr(ls_raddr), .ls_rdata(ls_rdata),
		.fs_we(fs_we), .fs_waddr(free_q[IDX_W-1:0]), .fs_wdata(slot_q),
		.fs_re(fs_re), .fs_raddr(free_m1[IDX_W-1:0]), .fs_slot(fs_slot)
	);

	ppe_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
		.clk(clk), .ctrl(ctrl), .dt(dt_q),
		.cam_x(camx_q), .cam_y(camy_q), .cam_z(camz_q), .rd(st_rdata),
		.vel_x(vx), .vel_y(vy), .vel_z(vz), .pos_x(px), .pos_y(py), .pos_z(pz),
		.acc_x(ax), .acc_y(ay), .acc_z(az), .sq_dist(sq_dist)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		st_we = 1'b0; st_re = 1'b0; ls_we = 1'b0; ls_re = 1'b0;
		fs_we = 1'b0; fs_re = 1'b0;
		st_waddr = slot_q;
		st_wdata = {life_q, az, ay, ax, vz, vy, vx, pz, py, px};
		st_raddr = ls_rdata;
		ls_waddr = {~sel_q, surv_q[IDX_W-1:0]};
		ls_wdata = slot_q;
		ls_raddr = {sel_q, i_q[IDX_W-1:0]};
		ctrl = '{load: 1'b0, opnd: 1'b0, mul: 1'b0, acc: 1'b0, op: op_q, axis: axis_q};
		case (st_q)
			S_IDLE: begin
				if (acc_in) begin
					case (kind_t'(s_tuser))
						K_EMIT: begin
							fs_re = grant_c;
							st_d = S_EMIT;
						end
						K_TICK:  st_d = S_LIST;
						default: st_d = S_IDLE;
					endcase
				end
			end
			S_EMIT: begin
				if (out_free) begin
					st_we = grant_q;
					st_waddr = fs_slot;
					st_wdata = inp_q;
					ls_we = grant_q;
					ls_waddr = {sel_q, alive_q[IDX_W-1:0]};
					ls_wdata = fs_slot;
					st_d = S_IDLE;
				end
			end
			S_LIST: begin
				if (i_q == n_q) begin
					st_d = S_END;
				end else begin
					ls_re = 1'b1;
					st_d = S_SLOT;
				end
			end
			S_SLOT: begin
				st_re = 1'b1;
				st_d = S_EVAL;
			end
			S_EVAL: begin
				ctrl.load = 1'b1;
				if (life_pos) begin
					st_d = S_OPND;
				end else begin
					fs_we = (free_q < MAX_C);
					st_d = S_LIST;
				end
			end
			S_OPND: begin
				ctrl.opnd = 1'b1;
				st_d = S_MUL;
			end
			S_MUL: begin
				ctrl.mul = 1'b1;
				st_d = S_ACC;
			end
			S_ACC: begin
				ctrl.acc = 1'b1;
				st_d = (op_q == OP_DIST && axis_q == 2'd2) ? S_WB : S_OPND;
			end
			S_WB: begin
				st_we = 1'b1;
				ls_we = (surv_q < MAX_C);
				st_d = S_PUSH;
			end
			S_PUSH: begin
				if (go) begin
					st_d = S_LIST;
				end
			end
			S_END: begin
				if (go) begin
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= DT_RESET;
			camx_q <= '0; camy_q <= '0; camz_q <= '0;
			sel_q <= 1'b0;
			free_q <= MAX_C;
			alive_q <= '0; granted_q <= '0; attempts_q <= '0; surv_q <= '0;
			i_q <= '0; n_q <= '0;
			grant_q <= 1'b0;
			pend_v_q <= 1'b0;
			op_q <= OP_VEL;
			axis_q <= '0;
			life_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (reg_t'(cfg_index))
					R_DT:    dt_q <= cfg_data[DT_W-1:0];
					R_CAMX:  camx_q <= cfg_data;
					R_CAMY:  camy_q <= cfg_data;
					R_CAMZ:  camz_q <= cfg_data;
					default: dt_q <= dt_q;
				endcase
			end
			if (m_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (acc_in) begin
						case (kind_t'(s_tuser))
							K_FRAME: begin
								attempts_q <= '0;
								granted_q <= (emit_cnt < {1'b0, free_q}) ?
									emit_cnt[CNT_W-1:0] : free_q;
								alive_q <= surv_q;
								surv_q <= '0;
							end
							K_EMIT: begin
								grant_q <= grant_c;
								if (grant_c) begin
									free_q <= free_m1;
								end
								if (attempts_q != '1) begin
									attempts_q <= attempts_q + CNT_W'(1);
								end
							end
							K_TICK: begin
								i_q <= '0;
								n_q <= alive_q;
							end
							default: i_q <= i_q;
						endcase
					end
				end
				S_EMIT: begin
					if (out_free && grant_q) begin
						alive_q <= alive_q + CNT_W'(1);
					end
				end
				S_EVAL: begin
					op_q <= OP_VEL;
					axis_q <= '0;
					life_q <= (life_dec < LIFE_MIN) ? {1'b1, {(VAL_W-1){1'b0}}}
						: life_dec[VAL_W-1:0];
					if (!life_pos) begin
						i_q <= i_q + CNT_W'(1);
						if (free_q < MAX_C) begin
							free_q <= free_q + CNT_W'(1);
						end
					end
				end
				S_ACC: begin
					if (axis_q == 2'd2) begin
						axis_q <= '0;
						op_q <= (op_q == OP_VEL) ? OP_POS : OP_DIST;
					end else begin
						axis_q <= axis_q + 2'd1;
					end
				end
				S_WB: begin
					if (surv_q < MAX_C) begin
						surv_q <= surv_q + CNT_W'(1);
					end
				end
				S_PUSH: begin
					if (go) begin
						pend_v_q <= 1'b1;
						i_q <= i_q + CNT_W'(1);
					end
				end
				S_END: begin
					if (go) begin
						pend_v_q <= 1'b0;
						sel_q <= ~sel_q;
					end
				end
				default: sel_q <= sel_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			inp_q <= s_tdata[IN_TDATA_W-1:EMIT_W];
		end
		if (st_q == S_SLOT) begin
			slot_q <= ls_rdata;
		end
		if (st_q == S_EMIT && out_free) begin
			m_tdata_q <= pack_out(grant_q ? SLOT_W'(fs_slot) : '0, grant_q,
				'0, '0, '0, '0);
			m_tuser_q <= RK_ACK;
			m_tlast_q <= 1'b1;
		end
		if ((st_q == S_PUSH || st_q == S_END) && go && pend_v_q) begin
			m_tdata_q <= pack_out(pend_slot_q, 1'b1, pend_x_q, pend_y_q, pend_z_q,
				pend_d_q);
			m_tuser_q <= RK_SURV;
			m_tlast_q <= (st_q == S_END);
		end
		if (st_q == S_PUSH && go) begin
			pend_slot_q <= SLOT_W'(slot_q);
			pend_x_q <= px;
			pend_y_q <= py;
			pend_z_q <= pz;
			pend_d_q <= sq_dist;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;
	assign m_tlast = m_tlast_q;

	`PPE_NEVER(a_free_range, free_q > MAX_C, "free count above pool size")
	`PPE_NEVER(a_alive_range, (alive_q > MAX_C) || (surv_q > MAX_C), "list count too big")
	`PPE_ASSERT(a_emit_room, (st_q == S_EMIT && grant_q) |-> (free_q < MAX_C), "grant without pop")
	`PPE_ASSERT(a_end_last, (st_q == S_END && go && pend_v_q) |=> (m_tvalid && m_tlast), "no last")
	`PPE_NEVER(a_pend_idle, st_q == S_IDLE && pend_v_q, "pending survivor left behind")
endmodule
`default_nettype wire
